// ===== rtl/cts_pkg.sv =====
// shared types and constants for the capture timestamp shifter
package cts_pkg;

  // time constants
  localparam logic [19:0] UsecPerSec = 20'd1000000;
  localparam logic [19:0] UsecMax    = 20'd999999;
  localparam logic [16:0] SecPerDay  = 17'd86400;

  // seconds / 86400 as (seconds >> 7) / 675 by reciprocal multiply
  localparam int unsigned TodShift = 35;
  localparam logic [25:0] TodRecip = 26'((64'd1 << TodShift) / 675);

  // register map, word index
  typedef enum logic [1:0] {
    RegShiftMode    = 2'd0,
    RegSubtract     = 2'd1,
    RegShiftSeconds = 2'd2,
    RegShiftMicros  = 2'd3
  } cfg_reg_t;

  // shift modes
  typedef enum logic [1:0] {
    ModeAbsolute  = 2'd0,
    ModeDate      = 2'd1,
    ModeTimeOfDay = 2'd2,
    ModeRelative  = 2'd3
  } shift_mode_t;

  // input word
  typedef struct packed {
    logic [31:0] in_seconds;
    logic [19:0] in_micros;
  } in_word_t;

  // result word
  typedef struct packed {
    logic [31:0] out_seconds;
    logic [19:0] out_micros;
  } out_word_t;

endpackage

// ===== rtl/cts_day_split.sv =====
// two-stage split of epoch seconds into start of day and time of day
module cts_day_split (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] sec_i,
  output logic [16:0] tod,
  output logic [31:0] sod
);

  logic [50:0] prod;
  logic [15:0] quot_r;
  logic [31:0] sec_a_r;
  logic [32:0] day_full;
  logic [31:0] day_r;
  logic [17:0] rem_r;
  logic        corr;

  // estimate of the day number, low by at most one
  assign prod = 51'(sec_i[31:7]) * 51'(cts_pkg::TodRecip);

  always_ff @(posedge clk) begin
    if (en) begin
      quot_r  <= prod[50:35];
      sec_a_r <= sec_i;
    end
  end

  // start of the estimated day and the remainder, below two days
  assign day_full = 33'(quot_r) * 33'(cts_pkg::SecPerDay);

  always_ff @(posedge clk) begin
    if (en) begin
      day_r <= day_full[31:0];
      rem_r <= sec_a_r[17:0] - day_full[17:0];
    end
  end

  // one correction step when the estimate was one day short
  assign corr = (rem_r >= 18'(cts_pkg::SecPerDay));
  assign tod  = corr ? 17'(rem_r - 18'(cts_pkg::SecPerDay)) : rem_r[16:0];
  assign sod  = corr ? day_r + 32'(cts_pkg::SecPerDay) : day_r;

endmodule

// ===== rtl/capture_timestamp_shift.sv =====
// capture timestamp shifter top level: register port, pipeline and result register
//
// Takes one timestamp word per cycle while in_stall is low and returns one shifted
// word per word, in order. The pipeline is the input register, then micro
// carry/borrow alongside the first of two reciprocal day split stages, the second
// day split stage with the target, the offset fix, and the final seconds add into
// the result register. It advances as one and holds only while the result register
// is full and out_stall is high. The first word after reset or after a register
// write fixes the seconds offset in the fourth stage; every later word uses that
// offset.
// Registers (32-bit, byte address 4*i): 0 shift_mode, 1 subtract_offset,
// 2 shift_seconds, 3 shift_micros. Write them only while no word is in flight.
module capture_timestamp_shift (
  input  logic                clk,
  input  logic                rst_n,
  // input words
  input  logic                in_valid,
  output logic                in_stall,
  input  cts_pkg::in_word_t   in_data,
  // result words
  output logic                out_valid,
  input  logic                out_stall,
  output cts_pkg::out_word_t  out_data,
  // register port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  typedef struct packed {
    logic [31:0] sec;
    logic        first;
    logic [19:0] us_add;
    logic        carry;
    logic [19:0] us_sub;
    logic        borrow;
  } item_t;

  cts_pkg::shift_mode_t shift_mode_r;
  logic                 subtract_r;
  logic [31:0]          shift_seconds_r;
  logic [19:0]          shift_micros_r;

  logic                 first_seen_r;
  logic [31:0]          applied_seconds_r;
  logic                 applied_subtract_r;
  logic [31:0]          applied_seconds_nxt;
  logic                 applied_subtract_nxt;

  logic                 en;
  logic                 accept;
  logic                 cfg_wr;
  cts_pkg::cfg_reg_t    cfg_idx;

  logic                 s1_valid_r, s2_valid_r, s3_valid_r, s4_valid_r, s5_valid_r;
  cts_pkg::in_word_t    s1_r;
  logic                 s1_first_r;
  item_t                s1_item;
  item_t                s2_r, s3_r, s4_r, s5_r;
  logic [31:0]          s4_target_r;
  logic [31:0]          target_nxt;

  logic [19:0]          us_sat;
  logic [19:0]          dus_sat;
  logic [20:0]          add_sum;

  logic [16:0]          tod;
  logic [31:0]          sod;
  logic                 fix_en;

  logic                 out_valid_r;
  cts_pkg::out_word_t   out_data_r;
  cts_pkg::out_word_t   out_nxt;

  // whole pipeline holds while a result waits on a stalled output
  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;
  assign accept   = in_valid && en;

  // register port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = cts_pkg::cfg_reg_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_mode_r    <= cts_pkg::ModeRelative;
      subtract_r      <= 1'b0;
      shift_seconds_r <= '0;
      shift_micros_r  <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        cts_pkg::RegShiftMode:    shift_mode_r    <= cts_pkg::shift_mode_t'(pwdata[1:0]);
        cts_pkg::RegSubtract:     subtract_r      <= pwdata[0];
        cts_pkg::RegShiftSeconds: shift_seconds_r <= pwdata;
        cts_pkg::RegShiftMicros:  shift_micros_r  <= pwdata[19:0];
        default:                  shift_mode_r    <= shift_mode_r;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (cfg_idx)
      cts_pkg::RegShiftMode:    prdata = 32'(shift_mode_r);
      cts_pkg::RegSubtract:     prdata = 32'(subtract_r);
      cts_pkg::RegShiftSeconds: prdata = shift_seconds_r;
      cts_pkg::RegShiftMicros:  prdata = 32'(shift_micros_r);
      default:                  prdata = '0;
    endcase
  end

  // first word flag: set on accept, cleared by a register write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_seen_r <= 1'b0;
    end else if (accept) begin
      first_seen_r <= 1'b1;
    end else if (cfg_wr) begin
      first_seen_r <= 1'b0;
    end
  end

  // pipeline valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      s4_valid_r  <= 1'b0;
      s5_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r  <= in_valid;
      s2_valid_r  <= s1_valid_r;
      s3_valid_r  <= s2_valid_r;
      s4_valid_r  <= s3_valid_r;
      s5_valid_r  <= s4_valid_r;
      out_valid_r <= s5_valid_r;
    end
  end

  // stage 1: saturate micros, prepare carry and borrow results
  always_comb begin
    us_sat  = (s1_r.in_micros > cts_pkg::UsecMax) ? cts_pkg::UsecMax : s1_r.in_micros;
    dus_sat = (shift_micros_r > cts_pkg::UsecMax) ? cts_pkg::UsecMax : shift_micros_r;
    add_sum = 21'(us_sat) + 21'(dus_sat);
    s1_item.sec    = s1_r.in_seconds;
    s1_item.first  = s1_first_r;
    s1_item.carry  = (add_sum >= 21'(cts_pkg::UsecPerSec));
    s1_item.us_add = s1_item.carry ? 20'(add_sum - 21'(cts_pkg::UsecPerSec)) : add_sum[19:0];
    s1_item.borrow = (dus_sat > us_sat);
    s1_item.us_sub = s1_item.borrow ? 20'(21'(us_sat) + 21'(cts_pkg::UsecPerSec) - 21'(dus_sat))
                                    : us_sat - dus_sat;
  end

  // stages 2 and 3: time of day split
  cts_day_split u_day_split (
    .clk   (clk),
    .en    (en),
    .sec_i (s1_r.in_seconds),
    .tod   (tod),
    .sod   (sod)
  );

  // stage 3: target time for the absolute modes
  always_comb begin
    unique case (shift_mode_r)
      cts_pkg::ModeDate:      target_nxt = shift_seconds_r + 32'(tod);
      cts_pkg::ModeTimeOfDay: target_nxt = sod + shift_seconds_r;
      default:                target_nxt = shift_seconds_r;
    endcase
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (en) begin
      s1_r        <= in_data;
      s1_first_r  <= !first_seen_r;
      s2_r        <= s1_item;
      s3_r        <= s2_r;
      s4_r        <= s3_r;
      s4_target_r <= target_nxt;
      s5_r        <= s4_r;
      out_data_r  <= out_nxt;
    end
  end

  // stage 4: fix the offset on the first word
  assign fix_en = en && s4_valid_r && s4_r.first;

  always_comb begin
    if (shift_mode_r == cts_pkg::ModeRelative) begin
      applied_seconds_nxt  = shift_seconds_r;
      applied_subtract_nxt = subtract_r;
    end else if (s4_r.sec > s4_target_r) begin
      applied_seconds_nxt  = s4_r.sec - s4_target_r;
      applied_subtract_nxt = 1'b1;
    end else begin
      applied_seconds_nxt  = s4_target_r - s4_r.sec;
      applied_subtract_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      applied_seconds_r  <= '0;
      applied_subtract_r <= 1'b0;
    end else if (fix_en) begin
      applied_seconds_r  <= applied_seconds_nxt;
      applied_subtract_r <= applied_subtract_nxt;
    end
  end

  // stage 5: apply seconds offset with micro carry or borrow
  always_comb begin
    if (applied_subtract_r) begin
      out_nxt.out_seconds = s5_r.sec - applied_seconds_r - 32'(s5_r.borrow);
      out_nxt.out_micros  = s5_r.us_sub;
    end else begin
      out_nxt.out_seconds = s5_r.sec + applied_seconds_r + 32'(s5_r.carry);
      out_nxt.out_micros  = s5_r.us_add;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // accepted word always leaves the first word flag set
  a_first_set: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> first_seen_r)
    else $error("first word flag not set after accept");

  // offset only moves when a first word passes the fix stage
  a_offset_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !fix_en |=> $stable(applied_seconds_r) && $stable(applied_subtract_r))
    else $error("offset changed without a first word");

  // day split is exact
  a_day_split: assert property (@(posedge clk) disable iff (!rst_n)
    s3_valid_r |-> (tod < cts_pkg::SecPerDay) && (sod + 32'(tod) == s3_r.sec))
    else $error("time of day split wrong");

  // result micros stay below one second
  a_micros_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.out_micros < cts_pkg::UsecPerSec))
    else $error("result micros out of range");

endmodule

// ===== sim/tb_capture_timestamp_shift.sv =====
// testbench for the capture timestamp shifter: directed table, then random capture streams
module tb_capture_timestamp_shift;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit  = 200000;
  localparam int HoldCycles  = 300;
  localparam int SegItems    = 105;
  localparam int SegsPerLoad = 6;
  localparam int DrainCycles = 12;
  localparam int DirRows     = 22;

  // block ports
  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  cts_pkg::in_word_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  cts_pkg::out_word_t out_data;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [3:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  capture_timestamp_shift u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #2 clk = ~clk;

  // shadow registers and fixed offset, at their reset values
  cts_pkg::shift_mode_t cur_mode     = cts_pkg::ModeRelative;
  logic                 cur_subtract = 1'b0;
  logic [31:0]          cur_seconds  = '0;
  logic [19:0]          cur_micros   = '0;
  logic                 offset_fixed = 1'b0;
  logic [31:0]          offset_secs  = '0;
  logic                 offset_sub   = 1'b0;

  cts_pkg::out_word_t pending_stamps[$];
  int                 errors = 0;
  int                 cycles = 0;
  int                 send_idle_pct = 0;
  int                 stall_pct = 0;
  int                 hold_ask = 0;
  int                 hold_seen = 0;
  int                 hold_left = 0;
  logic [31:0]        stream_sec = '0;
  logic [20:0]        stream_us = '0;

  // directed stimulus; want is used only where typed is set
  typedef struct packed {
    logic                 set_cfg;
    cts_pkg::shift_mode_t mode;
    logic                 sub;
    logic [31:0]          secs;
    logic [31:0]          usec;
    cts_pkg::in_word_t    stim;
    logic                 typed;
    cts_pkg::out_word_t   want;
  } dir_row_t;

  dir_row_t dir_rows [DirRows] = '{
    // after reset: zero relative offset
    '{1'b0, cts_pkg::ModeRelative, 1'b0, 32'd0, 32'd0, '{32'd0, 20'd0}, 1'b1,
      '{32'd0, 20'd0}},
    '{1'b0, cts_pkg::ModeRelative, 1'b0, 32'd0, 32'd0, '{32'hFFFF_FFFF, 20'd999999}, 1'b1,
      '{32'hFFFF_FFFF, 20'd999999}},
    '{1'b0, cts_pkg::ModeRelative, 1'b0, 32'd0, 32'd0, '{32'd7, 20'hF_FFFF}, 1'b1,
      '{32'd7, 20'd999999}},
    // relative add with carry and seconds wrap
    '{1'b1, cts_pkg::ModeRelative, 1'b0, 32'd1, 32'd1, '{32'hFFFF_FFFF, 20'd999999}, 1'b1,
      '{32'd1, 20'd0}},
    '{1'b0, cts_pkg::ModeRelative, 1'b0, 32'd1, 32'd1, '{32'd10, 20'd5}, 1'b1,
      '{32'd11, 20'd6}},
    // relative subtract with borrow
    '{1'b1, cts_pkg::ModeRelative, 1'b1, 32'd0, 32'd999999, '{32'd0, 20'd0}, 1'b1,
      '{32'hFFFF_FFFF, 20'd1}},
    '{1'b0, cts_pkg::ModeRelative, 1'b1, 32'd0, 32'd999999, '{32'd100, 20'd999999}, 1'b1,
      '{32'd100, 20'd0}},
    // oversized micros on both sides saturate
    '{1'b1, cts_pkg::ModeRelative, 1'b0, 32'd0, 32'h000F_FFFF, '{32'd5, 20'hF_FFFF}, 1'b1,
      '{32'd6, 20'd999998}},
    '{1'b1, cts_pkg::ModeRelative, 1'b1, 32'hFFFF_FFFF, 32'd0, '{32'd0, 20'd0}, 1'b1,
      '{32'd1, 20'd0}},
    // absolute target, first word behind and ahead of it
    '{1'b1, cts_pkg::ModeAbsolute, 1'b0, 32'd1000, 32'd0, '{32'd1500, 20'd7}, 1'b1,
      '{32'd1000, 20'd7}},
    '{1'b0, cts_pkg::ModeAbsolute, 1'b0, 32'd1000, 32'd0, '{32'd2000, 20'd0}, 1'b1,
      '{32'd1500, 20'd0}},
    '{1'b1, cts_pkg::ModeAbsolute, 1'b0, 32'd5000, 32'd0, '{32'd1000, 20'd3}, 1'b1,
      '{32'd5000, 20'd3}},
    '{1'b0, cts_pkg::ModeAbsolute, 1'b0, 32'd5000, 32'd0, '{32'd0, 20'd0}, 1'b1,
      '{32'd4000, 20'd0}},
    '{1'b1, cts_pkg::ModeAbsolute, 1'b1, 32'hFFFF_FFFF, 32'd500000, '{32'd0, 20'd600000},
      1'b0, '0},
    // date only keeps the time of day
    '{1'b1, cts_pkg::ModeDate, 1'b0, 32'd864000, 32'd0, '{32'd259300, 20'd0}, 1'b1,
      '{32'd864100, 20'd0}},
    '{1'b0, cts_pkg::ModeDate, 1'b0, 32'd864000, 32'd0, '{32'd345700, 20'd1}, 1'b0, '0},
    '{1'b1, cts_pkg::ModeDate, 1'b0, 32'd0, 32'd0, '{32'hFFFF_FFFF, 20'd0}, 1'b0, '0},
    // time of day only keeps the day
    '{1'b1, cts_pkg::ModeTimeOfDay, 1'b0, 32'd3600, 32'd0, '{32'd180000, 20'd0}, 1'b1,
      '{32'd176400, 20'd0}},
    '{1'b0, cts_pkg::ModeTimeOfDay, 1'b0, 32'd3600, 32'd0, '{32'd0, 20'd0}, 1'b0, '0},
    '{1'b1, cts_pkg::ModeTimeOfDay, 1'b0, 32'hFFFF_FFFF, 32'd999999, '{32'd86399, 20'd0},
      1'b0, '0},
    '{1'b1, cts_pkg::ModeTimeOfDay, 1'b0, 32'd0, 32'd250000, '{32'd432000, 20'd250000},
      1'b0, '0},
    '{1'b1, cts_pkg::ModeRelative, 1'b0, 32'd12345, 32'd0, '{32'd1, 20'd1}, 1'b0, '0}
  };

  // shifted timestamp of one word; fixes the offset on the first word
  function automatic cts_pkg::out_word_t shift_stamp(input cts_pkg::in_word_t w);
    logic [31:0]        sec;
    logic [20:0]        us;
    logic [19:0]        dus;
    logic [31:0]        tod;
    logic [31:0]        target;
    cts_pkg::out_word_t r;
    sec = w.in_seconds;
    us  = (w.in_micros > cts_pkg::UsecMax) ? 21'(cts_pkg::UsecMax) : 21'(w.in_micros);
    dus = (cur_micros > cts_pkg::UsecMax) ? cts_pkg::UsecMax : cur_micros;
    if (!offset_fixed) begin
      offset_fixed = 1'b1;
      tod = sec % 32'(cts_pkg::SecPerDay);
      case (cur_mode)
        cts_pkg::ModeAbsolute:  target = cur_seconds;
        cts_pkg::ModeDate:      target = cur_seconds + tod;
        cts_pkg::ModeTimeOfDay: target = sec - tod + cur_seconds;
        default:                target = '0;
      endcase
      if (cur_mode == cts_pkg::ModeRelative) begin
        offset_secs = cur_seconds;
        offset_sub  = cur_subtract;
      end else if (sec > target) begin
        offset_secs = sec - target;
        offset_sub  = 1'b1;
      end else begin
        offset_secs = target - sec;
        offset_sub  = 1'b0;
      end
    end
    if (offset_sub) begin
      sec = sec - offset_secs;
      if (21'(dus) > us) begin
        sec = sec - 32'd1;
        us  = us + 21'(cts_pkg::UsecPerSec) - 21'(dus);
      end else begin
        us = us - 21'(dus);
      end
    end else begin
      sec = sec + offset_secs;
      us  = us + 21'(dus);
      if (us >= 21'(cts_pkg::UsecPerSec)) begin
        sec = sec + 32'd1;
        us  = us - 21'(cts_pkg::UsecPerSec);
      end
    end
    r.out_seconds = sec;
    r.out_micros  = us[19:0];
    return r;
  endfunction

  // seconds with extremes and day boundaries mixed in
  function automatic logic [31:0] rand_seconds();
    case ($urandom_range(7))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'($urandom_range(0, 200000));
      3:       return 32'($urandom_range(0, 49000)) * 32'(cts_pkg::SecPerDay);
      4:       return 32'($urandom_range(0, 49000)) * 32'(cts_pkg::SecPerDay)
                      + 32'(cts_pkg::SecPerDay) - 32'd1;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] cfg_value(input cts_pkg::cfg_reg_t idx);
    case (idx)
      cts_pkg::RegShiftSeconds: return rand_seconds();
      cts_pkg::RegShiftMicros: begin
        case ($urandom_range(4))
          0:       return 32'd0;
          1:       return 32'(cts_pkg::UsecMax);
          2:       return $urandom();
          default: return 32'($urandom_range(0, 999999));
        endcase
      end
      default: return $urandom();
    endcase
  endfunction

  // mostly a running capture clock, the rest scattered words
  function automatic cts_pkg::in_word_t next_stamp();
    cts_pkg::in_word_t w;
    if ($urandom_range(9) < 7) begin
      stream_us = stream_us + 21'($urandom_range(0, 400000));
      if (stream_us >= 21'(cts_pkg::UsecPerSec)) begin
        stream_us  = stream_us - 21'(cts_pkg::UsecPerSec);
        stream_sec = stream_sec + 32'd1;
      end
      if ($urandom_range(15) == 0) stream_sec = stream_sec + 32'($urandom_range(1, 90000));
      w.in_seconds = stream_sec;
      w.in_micros  = stream_us[19:0];
    end else begin
      w.in_seconds = rand_seconds();
      w.in_micros  = ($urandom_range(3) == 0) ? 20'($urandom()) : 20'($urandom_range(0, 999999));
    end
    return w;
  endfunction

  // offer one word, called and returning at a falling edge
  task automatic send_word(input cts_pkg::in_word_t w, input logic typed,
                           input cts_pkg::out_word_t want);
    cts_pkg::out_word_t got;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    got = shift_stamp(w);
    pending_stamps.push_back(typed ? want : got);
    @(negedge clk);
  endtask

  // register write: setup then access phase
  task automatic cfg_write(input cts_pkg::cfg_reg_t idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      cts_pkg::RegShiftMode:    cur_mode = cts_pkg::shift_mode_t'(val[1:0]);
      cts_pkg::RegSubtract:     cur_subtract = val[0];
      cts_pkg::RegShiftSeconds: cur_seconds = val;
      cts_pkg::RegShiftMicros:  cur_micros = val[19:0];
      default: ;
    endcase
    offset_fixed = 1'b0;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // stop offering and wait for every expected word
  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_stamps.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  function automatic void note_mismatch(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
    errors++;
    $error("%s expected %0d actual %0d", what, want, got);
  endfunction

  // receiver: random stall, or a long hold when asked
  always @(negedge clk) begin
    if (hold_left == 0 && hold_seen != hold_ask) begin
      hold_seen = hold_ask;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    cts_pkg::out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_stamps.size() == 0) begin
        note_mismatch("unexpected word out_seconds", 32'd0, out_data.out_seconds);
      end else begin
        want = pending_stamps.pop_front();
        if (out_data.out_seconds !== want.out_seconds)
          note_mismatch("out_seconds", want.out_seconds, out_data.out_seconds);
        if (out_data.out_micros !== want.out_micros)
          note_mismatch("out_micros", 32'(want.out_micros), 32'(out_data.out_micros));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    logic [3:0] pick;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table
    send_idle_pct = 12;
    stall_pct     = 64;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].set_cfg) begin
        drain_results();
        cfg_write(cts_pkg::RegShiftMode, 32'(dir_rows[i].mode));
        cfg_write(cts_pkg::RegSubtract, 32'(dir_rows[i].sub));
        cfg_write(cts_pkg::RegShiftSeconds, dir_rows[i].secs);
        cfg_write(cts_pkg::RegShiftMicros, dir_rows[i].usec);
      end
      send_word(dir_rows[i].stim, dir_rows[i].typed, dir_rows[i].want);
    end

    // random segments under three idle profiles
    for (int p = 0; p < 3; p++) begin
      case (p)
        0:       begin send_idle_pct = 12; stall_pct = 64; end
        1:       begin send_idle_pct = 64; stall_pct = 12; end
        default: begin send_idle_pct = 0;  stall_pct = 0;  end
      endcase
      for (int s = 0; s < SegsPerLoad; s++) begin
        drain_results();
        pick = (s == 0) ? 4'hF : 4'($urandom_range(1, 15));
        for (int r = 0; r < 4; r++)
          if (pick[r]) cfg_write(cts_pkg::cfg_reg_t'(r), cfg_value(cts_pkg::cfg_reg_t'(r)));
        stream_sec = rand_seconds();
        stream_us  = 21'($urandom_range(0, 999999));
        for (int n = 0; n < SegItems; n++) begin
          // long receiver hold so the pipeline fills and stalls its input
          if (p == 2 && s == 1 && n == 10) hold_ask++;
          // sender pause until the pipeline is empty
          if (s == 2 && n == 60) drain_results();
          send_word(next_stamp(), 1'b0, '0);
        end
      end
    end

    drain_results();
    if (errors == 0 && pending_stamps.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
